// ----- rtl/sphere_frustum_cull_core_macros.svh -----
// Assertion macros shared by the sphere/frustum culling RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SPHERE_FRUSTUM_CULL_CORE_MACROS_SVH
`define SPHERE_FRUSTUM_CULL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sfc_pkg.sv -----
// Package for the sphere/frustum culling core: opcodes, sequencer states and
// the tag that travels with each term through the shared multiply-accumulate unit.
`timescale 1ns / 1ps

package sfc_pkg;

  // Accumulator width: three exact Q32.32 products plus a shifted bias.
  localparam int ACC_W = 67;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
  localparam logic [1:0] OP_LOAD_MATRIX = 2'd1;
  localparam logic [1:0] OP_TEST_DIRECT = 2'd2;
  localparam logic [1:0] OP_TEST_XFORM  = 2'd3;

  // Terms per dot product: one bias term and three products.
  localparam logic [1:0] LAST_TERM    = 2'd3;
  // Last transform column computed (x, y, z).
  localparam logic [2:0] LAST_XF_DOT  = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFORM,
    ST_XDRAIN,
    ST_PLANE,
    ST_PDRAIN
  } sfc_state_t;

  // Sideband for one term in flight. dot is wide enough for up to eight planes.
  typedef struct packed {
    logic       vld;
    logic       bias;
    logic       last;
    logic       xf;
    logic [2:0] dot;
  } sfc_tag_t;

endpackage

// ----- rtl/sfc_mac.sv -----
// Shared multiply-accumulate unit: one registered 32x32 signed multiply, then
// a wide accumulate. Depends on sfc_pkg for the term tag and accumulator width.
`timescale 1ns / 1ps

module sfc_mac
  import sfc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  sfc_tag_t                tag_in,
  input  logic signed [31:0]      op_a,
  input  logic signed [31:0]      op_b,
  output sfc_tag_t                tag_out,
  output logic signed [ACC_W-1:0] acc,
  output logic                    busy
);

  sfc_tag_t                prod_tag_r;
  logic signed [63:0]      prod_r;
  logic signed [63:0]      prod_nxt;
  sfc_tag_t                acc_tag_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  // A bias term enters as the Q16.16 value scaled to Q32.32.
  always_comb begin
    if (tag_in.bias) begin
      prod_nxt = {{16{op_a[31]}}, op_a, 16'h0000};
    end else begin
      prod_nxt = op_a * op_b;
    end
  end

  // The bias term always opens a dot product, so it loads the accumulator.
  always_comb begin
    if (prod_tag_r.bias) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_tag_r <= '0;
      acc_tag_r  <= '0;
    end else begin
      prod_tag_r <= tag_in;
      acc_tag_r  <= prod_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_in.vld) begin
      prod_r <= prod_nxt;
    end
    if (prod_tag_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign tag_out = acc_tag_r;
  assign acc     = acc_r;
  assign busy    = prod_tag_r.vld;

endmodule

// ----- rtl/sphere_frustum_cull_core.sv -----
// Sphere/frustum culling core: top level with plane and matrix stores and the
// term sequencer. Depends on sfc_pkg, sfc_mac and the assertion macro header.
`timescale 1ns / 1ps

// A load transfer (op 0 or 1) writes one plane coefficient or one world-matrix
// element. A test transfer (op 2 or 3) is worked one term per cycle through a
// single shared multiply-accumulate unit: every dot product is one bias term
// plus three products, and each pass of dot products is followed by a pipeline
// drain through the memory read, multiply and accumulate registers. A direct
// test (op 2) runs one dot product per plane; a transformed test (op 3) first
// runs three transform dot products and one drain. The input is not ready while a
// test is in progress. The visibility result sits in an output register, so
// loads and the next test can be accepted while it waits to be taken. Both
// stores have no reset; a test must only read entries that were loaded.
`include "sphere_frustum_cull_core_macros.svh"

module sphere_frustum_cull_core
  import sfc_pkg::*;
#(
  parameter int NUM_PLANES = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, lowest bit up: row_sel[2:0], col_sel[4:3], load_value[36:5],
  // center_x[68:37], center_y[100:69], center_z[132:101], radius[163:133],
  // zero padding[167:164].
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,
  // in_tuser: op[1:0].
  input  logic [1:0]   in_tuser,
  // out_tdata, lowest bit up: visible[0], zero padding[7:1].
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata
);

  localparam int PLANE_DEPTH = NUM_PLANES * 4;
  localparam int PA_W        = $clog2(PLANE_DEPTH);

  // Input fields.
  logic [1:0]         in_op;
  logic [2:0]         in_row_sel;
  logic [1:0]         in_col_sel;
  logic signed [31:0] in_load_value;
  logic signed [31:0] in_center [3];
  logic [30:0]        in_radius;

  assign in_op         = in_tuser;
  assign in_row_sel    = in_tdata[2:0];
  assign in_col_sel    = in_tdata[4:3];
  assign in_load_value = in_tdata[36:5];
  assign in_center[0]  = in_tdata[68:37];
  assign in_center[1]  = in_tdata[100:69];
  assign in_center[2]  = in_tdata[132:101];
  assign in_radius     = in_tdata[163:133];

  logic in_xfer;
  logic test_xfer;
  assign in_xfer   = in_tvalid && in_tready;
  assign test_xfer = in_xfer && (in_op == OP_TEST_DIRECT || in_op == OP_TEST_XFORM);

  // Coefficient stores. Plane entry index is plane*4 + coeff, matrix is row*4 + col.
  logic signed [31:0] plane_mem [PLANE_DEPTH];
  logic signed [31:0] mat_mem   [16];
  logic [PA_W-1:0]    plane_waddr;
  logic [PA_W-1:0]    plane_raddr;
  logic [3:0]         mat_raddr;
  logic signed [31:0] plane_rd_r;
  logic signed [31:0] mat_rd_r;
  logic               plane_we;
  logic               mat_we;

  assign plane_waddr = PA_W'({in_row_sel, in_col_sel});
  assign plane_we    = in_xfer && (in_op == OP_LOAD_PLANE)
                       && ({1'b0, in_row_sel} < 4'(NUM_PLANES));
  assign mat_we      = in_xfer && (in_op == OP_LOAD_MATRIX) && !in_row_sel[2];

  always_ff @(posedge clk) begin
    if (plane_we) begin
      plane_mem[plane_waddr] <= in_load_value;
    end
    if (mat_we) begin
      mat_mem[{in_row_sel[1:0], in_col_sel}] <= in_load_value;
    end
  end

  always_ff @(posedge clk) begin
    plane_rd_r <= plane_mem[plane_raddr];
    mat_rd_r   <= mat_mem[mat_raddr];
  end

  // Sequencer state and term counters.
  sfc_state_t state_r;
  sfc_state_t state_nxt;
  logic [1:0] term_r;
  logic [1:0] term_nxt;
  logic [2:0] dot_r;
  logic [2:0] dot_nxt;

  // Test operands: ctr_r is the centre as given, pt_r the point the planes see.
  logic signed [31:0] ctr_r [3];
  logic signed [31:0] pt_r  [3];
  logic [30:0]        rad_r;
  logic               vis_r;

  logic       out_tvalid_r;
  logic       out_tvalid_nxt;
  logic       out_vis_r;

  // Issue stage: one term per cycle in the two working states.
  logic       iss_vld;
  logic       iss_xf;
  logic [1:0] coeff_idx;
  logic [1:0] coord_idx;

  // Memory-read stage registers.
  sfc_tag_t           s1_tag_r;
  logic signed [31:0] s1_coord_r;
  logic signed [31:0] mac_a;

  // Accumulate stage outputs.
  sfc_tag_t                mac_tag;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    mac_busy;

  logic pipe_empty;
  logic finish;
  logic dot_done;

  assign iss_vld   = (state_r == ST_XFORM) || (state_r == ST_PLANE);
  assign iss_xf    = (state_r == ST_XFORM);
  // The bias sits at coefficient d (plane) or matrix row 3; wrapping term 0 gives 3.
  assign coeff_idx = term_r - 2'd1;
  assign coord_idx = (term_r == 2'd0) ? 2'd0 : coeff_idx;

  assign plane_raddr = PA_W'({dot_r, coeff_idx});
  assign mat_raddr   = {coeff_idx, dot_r[1:0]};

  assign pipe_empty = !s1_tag_r.vld && !mac_busy && !mac_tag.vld;
  assign finish     = (state_r == ST_PDRAIN) && pipe_empty
                      && (!out_tvalid_r || out_tready);
  assign dot_done   = (term_r == LAST_TERM);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (test_xfer) begin
          state_nxt = (in_op == OP_TEST_XFORM) ? ST_XFORM : ST_PLANE;
        end
      end
      ST_XFORM: begin
        if (dot_done && dot_r == LAST_XF_DOT) begin
          state_nxt = ST_XDRAIN;
        end
      end
      ST_XDRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_PLANE;
        end
      end
      ST_PLANE: begin
        if (dot_done && dot_r == 3'(NUM_PLANES - 1)) begin
          state_nxt = ST_PDRAIN;
        end
      end
      ST_PDRAIN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: term counters and the result register's valid.
  always_comb begin
    term_nxt = term_r;
    dot_nxt  = dot_r;
    unique case (state_r)
      ST_IDLE, ST_XDRAIN: begin
        term_nxt = 2'd0;
        dot_nxt  = 3'd0;
      end
      ST_XFORM, ST_PLANE: begin
        term_nxt = term_r + 2'd1;
        if (dot_done) begin
          dot_nxt = dot_r + 3'd1;
        end
      end
      ST_PDRAIN: begin
        term_nxt = term_r;
        dot_nxt  = dot_r;
      end
      default: begin
        term_nxt = 2'd0;
        dot_nxt  = 3'd0;
      end
    endcase

    if (finish) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      term_r       <= 2'd0;
      dot_r        <= 3'd0;
      out_tvalid_r <= 1'b0;
      s1_tag_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      term_r       <= term_nxt;
      dot_r        <= dot_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      s1_tag_r.vld  <= iss_vld;
      s1_tag_r.bias <= (term_r == 2'd0);
      s1_tag_r.last <= dot_done;
      s1_tag_r.xf   <= iss_xf;
      s1_tag_r.dot  <= dot_r;
    end
  end

  // Coordinate operand is captured alongside the memory read.
  always_ff @(posedge clk) begin
    if (iss_xf) begin
      s1_coord_r <= ctr_r[coord_idx];
    end else begin
      s1_coord_r <= pt_r[coord_idx];
    end
  end

  assign mac_a = s1_tag_r.xf ? mat_rd_r : plane_rd_r;

  sfc_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (s1_tag_r),
    .op_a    (mac_a),
    .op_b    (s1_coord_r),
    .tag_out (mac_tag),
    .acc     (mac_acc),
    .busy    (mac_busy)
  );

  // Dot product finish: floor to Q16.16 by dropping the low 16 bits.
  logic signed [50:0] dot_q;
  logic signed [50:0] neg_rad;
  logic               dot_fits;
  logic signed [31:0] dot_sat;
  logic               eval_vld;

  assign dot_q    = mac_acc[66:16];
  assign neg_rad  = -$signed({20'd0, rad_r});
  assign dot_fits = (dot_q[50:31] == {20{dot_q[50]}});
  assign dot_sat  = dot_fits ? dot_q[31:0]
                  : (dot_q[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign eval_vld = mac_tag.vld && mac_tag.last;

  always_ff @(posedge clk) begin
    if (test_xfer) begin
      for (int k = 0; k < 3; k++) begin
        ctr_r[k] <= in_center[k];
        pt_r[k]  <= in_center[k];
      end
      rad_r <= in_radius;
      vis_r <= 1'b1;
    end else if (eval_vld) begin
      if (mac_tag.xf) begin
        // A transformed coordinate replaces the given one for the plane pass.
        pt_r[mac_tag.dot[1:0]] <= dot_sat;
      end else if (dot_q < neg_rad) begin
        vis_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_vis_r <= vis_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_vis_r};

  // Nothing may be in flight while new work can be accepted.
  `SFC_ASSERT_NOW(a_idle_pipe_empty, in_tready, !s1_tag_r.vld && !mac_busy && !mac_tag.vld, "pipeline active while ready")
  // A transform result only lands during the transform pass.
  `SFC_ASSERT_NOW(a_xf_eval_state, eval_vld && mac_tag.xf, state_r == ST_XFORM || state_r == ST_XDRAIN, "transform result outside transform pass")
  // A plane result only lands during the plane pass.
  `SFC_ASSERT_NOW(a_plane_eval_state, eval_vld && !mac_tag.xf, state_r == ST_PLANE || state_r == ST_PDRAIN, "plane result outside plane pass")
  // An accepted test starts issuing terms in the next cycle.
  `SFC_ASSERT_NEXT(a_test_starts, test_xfer, state_r == ST_XFORM || state_r == ST_PLANE, "test accepted without starting")
  // Leaving the drain always presents a result.
  `SFC_ASSERT_NEXT(a_finish_result, finish, out_tvalid_r, "finished test without result")

endmodule

// ----- tb/sv/cull_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the sphere/frustum culling core: mirrors the plane and world-matrix
// stores from observed load transfers and predicts every visibility result.
// Depends on sfc_pkg for the operation codes.

module cull_checker
  import sfc_pkg::*;
#(
  parameter int NUM_PLANES = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [167:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [7:0]   out_tdata,
  output int           mismatches,
  output int           pending,
  output int           culled
);

  localparam int PA_W = $clog2(NUM_PLANES * 4);

  typedef logic signed [79:0] wide_t;

  logic signed [31:0] plane_mem [NUM_PLANES*4];  // index plane*4 + coefficient
  logic signed [31:0] world_mat [16];            // index row*4 + column
  logic               visible_q [$];
  int                 n_bad = 0;
  int                 n_culled = 0;

  // floor((a0*b0 + a1*b1 + a2*b2) / 2^16) + bias, all exact in 80 bits.
  function automatic wide_t dot_floor(input logic signed [31:0] a0, a1, a2, b0, b1, b2,
                                      input logic signed [31:0] bias);
    wide_t acc, p0, p1, p2, q0, q1, q2;
    p0 = a0;
    p1 = a1;
    p2 = a2;
    q0 = b0;
    q1 = b1;
    q2 = b2;
    acc = bias;
    acc = (acc <<< 16) + p0 * q0 + p1 * q1 + p2 * q2;
    return acc >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(input wide_t v);
    if (v > 80'sd2147483647)
      return 32'sh7FFF_FFFF;
    if (v < -80'sd2147483648)
      return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic sphere_visible(input logic [1:0] op,
                                          input logic signed [31:0] cx, cy, cz,
                                          input logic [30:0] rad);
    logic signed [31:0] px, py, pz;
    wide_t              neg_rad;
    int                 i;
    px = cx;
    py = cy;
    pz = cz;
    if (op == OP_TEST_XFORM) begin
      // Row-vector point with w = 1: column j of the matrix, row 3 as translation.
      px = clamp32(dot_floor(cx, cy, cz, world_mat[0], world_mat[4], world_mat[8],
                             world_mat[12]));
      py = clamp32(dot_floor(cx, cy, cz, world_mat[1], world_mat[5], world_mat[9],
                             world_mat[13]));
      pz = clamp32(dot_floor(cx, cy, cz, world_mat[2], world_mat[6], world_mat[10],
                             world_mat[14]));
    end
    neg_rad = -$signed({49'd0, rad});
    for (i = 0; i < NUM_PLANES; i++) begin
      if (dot_floor(plane_mem[PA_W'(4 * i)], plane_mem[PA_W'(4 * i + 1)],
                    plane_mem[PA_W'(4 * i + 2)], px, py, pz,
                    plane_mem[PA_W'(4 * i + 3)]) < neg_rad)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [2:0] row;
    logic [1:0] col;
    logic       exp_vis;
    row = in_tdata[2:0];
    col = in_tdata[4:3];
    if (rst_n) begin
      // Results first: a result never belongs to a test accepted at the same edge.
      if (out_tvalid && out_tready) begin
        if (visible_q.size() == 0) begin
          n_bad++;
          $display("%0t: unexpected result: expected none, actual visible=%0b",
                   $time, out_tdata[0]);
        end else begin
          exp_vis = visible_q.pop_front();
          if (out_tdata[0] !== exp_vis) begin
            n_bad++;
            $display("%0t: visible mismatch: expected %0b, actual %0b",
                     $time, exp_vis, out_tdata[0]);
          end
        end
        if (out_tdata[0] === 1'b0)
          n_culled++;
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          OP_LOAD_PLANE:
            if (int'(row) < NUM_PLANES)
              plane_mem[PA_W'({row, col})] = in_tdata[36:5];
          OP_LOAD_MATRIX:
            if (row < 3'd4)
              world_mat[{row[1:0], col}] = in_tdata[36:5];
          default:
            visible_q.push_back(sphere_visible(in_tuser, in_tdata[68:37], in_tdata[100:69],
                                               in_tdata[132:101], in_tdata[163:133]));
        endcase
      end
    end
    mismatches <= n_bad;
    pending    <= visible_q.size();
    culled     <= n_culled;
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the sphere/frustum culling testbench: clock, reset, stimulus, output
// pacing and the verdict. Depends on sfc_pkg, cull_checker and the core RTL.

module testbench;
  import sfc_pkg::*;

  localparam int NUM_PLANES     = 6;
  localparam int ONE            = 32'h0001_0000;  // 1.0 in Q16.16
  localparam int RANDOM_ITEMS   = 630;
  localparam int HOLD_CYCLES    = 400;            // long output hold-off in the first phase
  localparam int DRAIN_CYCLES   = 64;             // longer than a transformed test
  localparam int WATCHDOG_LIMIT = 3000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // in_tdata, lowest bit up: row_sel, col_sel, load_value, center_x, center_y,
  // center_z, radius, zero padding.
  logic [167:0] in_tdata = '0;
  // in_tuser: op.
  logic [1:0]   in_tuser = OP_LOAD_PLANE;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // out_tdata, lowest bit up: visible, zero padding.
  logic [7:0]   out_tdata;

  int mismatches;
  int pending;
  int culled;

  // Pacing knobs, in percent of cycles, changed once per phase.
  int idle_pct  = 0;
  int stall_pct = 0;
  // The stimulus flips hold_ask to request one long hold-off; the output side
  // notices the change and counts the stretch down itself.
  logic hold_ask  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int n_sent  = 0;
  int n_loads = 0;
  int n_tests = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sphere_frustum_cull_core #(
    .NUM_PLANES(NUM_PLANES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  cull_checker #(
    .NUM_PLANES(NUM_PLANES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .pending   (pending),
    .culled    (culled)
  );

  // Output side. Outside a hold-off, out_tready drops at random with the
  // current stall rate. While a hold-off runs, results back up in the output
  // register and the core eventually stops taking new tests.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen  <= hold_ask;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a run that stops moving on both channels for too long is a failure.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, giving up", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Uniform value in [-span, span].
  function automatic logic [31:0] nice(input int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // One input transfer. Fields the operation does not use are filled with
  // random values, since the core must ignore them. tvalid stays high from one
  // transfer to the next unless a random gap is inserted.
  task automatic send(input logic [1:0] op, input int row, input int col,
                      input logic [31:0] val, input logic [31:0] cx, cy, cz,
                      input logic [31:0] rad);
    if (op == OP_LOAD_PLANE || op == OP_LOAD_MATRIX) begin
      cx  = $urandom();
      cy  = $urandom();
      cz  = $urandom();
      rad = $urandom();
      n_loads++;
    end else begin
      row = $urandom_range(7);
      col = $urandom_range(3);
      val = $urandom();
      n_tests++;
    end
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, 31'(rad), cz, cy, cx, val, 2'(col), 3'(row)};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    n_sent++;
  endtask

  task automatic load_plane(input int p, input logic [31:0] a, b, c, d);
    send(OP_LOAD_PLANE, p, 0, a, 0, 0, 0, 0);
    send(OP_LOAD_PLANE, p, 1, b, 0, 0, 0, 0);
    send(OP_LOAD_PLANE, p, 2, c, 0, 0, 0, 0);
    send(OP_LOAD_PLANE, p, 3, d, 0, 0, 0, 0);
  endtask

  // A test with a moderate centre and radius, so that both outcomes are common.
  task automatic nice_test(input logic [1:0] op);
    send(op, 0, 0, 0, nice(256 * ONE), nice(256 * ONE), nice(256 * ONE),
         $urandom_range(64 * ONE));
  endtask

  // One random step. Most of it is well-formed: planes with normals within
  // +-1.0 and offsets within +-200.0, matrix elements within +-2.0, and tests
  // with moderate spheres. The rest is full-range values, loads aimed at rows
  // that do not exist, and short runs through an extreme coefficient that is
  // repaired right after.
  task automatic random_item();
    int pick;
    int p;
    int r;
    int c;
    pick = $urandom_range(99);
    p    = $urandom_range(NUM_PLANES - 1);
    r    = $urandom_range(3);
    c    = $urandom_range(3);
    if (pick < 10) begin
      load_plane(p, nice(ONE), nice(ONE), nice(ONE), nice(200 * ONE));
    end else if (pick < 16) begin
      send(OP_LOAD_MATRIX, r, c, nice(2 * ONE), 0, 0, 0, 0);
    end else if (pick < 20) begin
      if ($urandom_range(1))
        send(OP_LOAD_PLANE, $urandom_range(7, NUM_PLANES), c, $urandom(), 0, 0, 0, 0);
      else
        send(OP_LOAD_MATRIX, $urandom_range(7, 4), c, $urandom(), 0, 0, 0, 0);
    end else if (pick < 22) begin
      send(OP_LOAD_PLANE, p, c, $urandom(), 0, 0, 0, 0);
      nice_test(OP_TEST_DIRECT);
      nice_test(OP_TEST_XFORM);
      load_plane(p, nice(ONE), nice(ONE), nice(ONE), nice(200 * ONE));
    end else if (pick < 24) begin
      send(OP_LOAD_MATRIX, r, c, $urandom(), 0, 0, 0, 0);
      nice_test(OP_TEST_XFORM);
      nice_test(OP_TEST_XFORM);
      send(OP_LOAD_MATRIX, r, c, nice(2 * ONE), 0, 0, 0, 0);
    end else if (pick < 86) begin
      nice_test($urandom_range(1) ? OP_TEST_XFORM : OP_TEST_DIRECT);
    end else begin
      send($urandom_range(1) ? OP_TEST_XFORM : OP_TEST_DIRECT, 0, 0, 0,
           $urandom(), $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    int r;
    int c;
    int ph;
    int quota;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Setup: both stores are written in full before any test reads them. The
    // planes form an axis-aligned box of half-width 100.0, and the matrix is
    // the identity with a translation of 10.0 along x.
    load_plane(0,  ONE, 0, 0, 100 * ONE);
    load_plane(1, -ONE, 0, 0, 100 * ONE);
    load_plane(2, 0,  ONE, 0, 100 * ONE);
    load_plane(3, 0, -ONE, 0, 100 * ONE);
    load_plane(4, 0, 0,  ONE, 100 * ONE);
    load_plane(5, 0, 0, -ONE, 100 * ONE);
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++)
        send(OP_LOAD_MATRIX, r, c, (r == c) ? ONE : (r == 3 && c == 0) ? 10 * ONE : 0,
             0, 0, 0, 0);

    // Directed: inside, outside, and exactly touching a face (equality with
    // the negated radius counts as visible), then one ulp less radius.
    send(OP_TEST_DIRECT, 0, 0, 0, 0, 0, 0, 0);
    send(OP_TEST_DIRECT, 0, 0, 0, -101 * ONE, 0, 0, 0);
    send(OP_TEST_DIRECT, 0, 0, 0, -101 * ONE, 0, 0, ONE);
    send(OP_TEST_DIRECT, 0, 0, 0, -101 * ONE, 0, 0, ONE - 1);
    // Extreme centres and the largest radius.
    send(OP_TEST_DIRECT, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send(OP_TEST_DIRECT, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF);
    // Transformed tests across the translated face.
    send(OP_TEST_XFORM, 0, 0, 0, -111 * ONE, 0, 0, 0);
    send(OP_TEST_XFORM, 0, 0, 0, -110 * ONE, 0, 0, 0);
    // Flooring of the transformed coordinate: x/2 - 100.0 lands one ulp
    // outside for x = -1 ulp and exactly on the face for x = +1 ulp.
    send(OP_LOAD_MATRIX, 0, 0, 32'h0000_8000, 0, 0, 0, 0);
    send(OP_LOAD_MATRIX, 3, 0, -100 * ONE, 0, 0, 0, 0);
    send(OP_TEST_XFORM, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send(OP_TEST_XFORM, 0, 0, 0, 1, 0, 0, 0);
    // Saturation of the transformed coordinate in both directions.
    send(OP_LOAD_MATRIX, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send(OP_LOAD_MATRIX, 3, 0, 0, 0, 0, 0, 0);
    send(OP_TEST_XFORM, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    send(OP_TEST_XFORM, 0, 0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF);
    // Loads to rows that do not exist must leave both stores alone.
    send(OP_LOAD_PLANE, 6, 0, 32'h8000_0000, 0, 0, 0, 0);
    send(OP_LOAD_PLANE, 7, 3, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send(OP_LOAD_MATRIX, 4, 0, 32'h8000_0000, 0, 0, 0, 0);
    send(OP_LOAD_MATRIX, 7, 3, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send(OP_TEST_XFORM, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    // Most negative plane coefficient against both extreme centres.
    send(OP_LOAD_PLANE, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
    send(OP_TEST_DIRECT, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
    send(OP_TEST_DIRECT, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    send(OP_LOAD_PLANE, 0, 0, ONE, 0, 0, 0, 0);
    send(OP_LOAD_MATRIX, 0, 0, ONE, 0, 0, 0, 0);

    // Random part in four pacing phases: free flow with one long output
    // hold-off, a sparse sender, a stalling receiver, and both at once.
    quota = n_sent;
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  <= (ph == 1) ? 51 : (ph == 3) ? 32 : 0;
      stall_pct <= (ph == 2) ? 51 : (ph == 3) ? 32 : 0;
      if (ph == 0)
        hold_ask <= ~hold_ask;
      quota = quota + RANDOM_ITEMS / 4;
      while (n_sent < quota)
        random_item();
    end
    in_tvalid <= 1'b0;
    idle_pct  <= 0;
    stall_pct <= 0;

    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transfers: %0d loads and %0d sphere tests, %0d of them culled,",
             n_sent, n_loads, n_tests, culled);
    $display("under free flow, sender gaps, receiver stalls and one long output hold-off.");
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
